// ===== design/wts_pkg.sv =====
// shared constants, types and the arctangent table for the waypoint target selector
// used by the interfaces, the top level and the testbench; no dependencies
package wts_pkg;

    localparam int MAX_POINTS   = 256;
    localparam int ADDR_W       = $clog2(MAX_POINTS);
    localparam int CNT_W        = $clog2(MAX_POINTS + 1);
    localparam int CORDIC_STEPS = 16;
    localparam int ITER_W       = $clog2(CORDIC_STEPS + 1);
    localparam int COORD_W      = 32;
    localparam int THR_W        = 31;
    localparam int HEAD_W       = 16;
    localparam int VEC_W        = 35;
    localparam int ANG_W        = 34;

    localparam logic [THR_W-1:0]  THR_RESET     = 31'd6554;
    localparam logic [ANG_W-1:0]  HALF_PI_Q30   = 34'sd1686629713;
    localparam logic [ANG_W-1:0]  ROUND_BIAS    = 34'sd65536;
    localparam logic [ANG_W-1:0]  HEADING_LIMIT = 34'sd25736;

    typedef logic [COORD_W-1:0] coord_t;

    function automatic logic [ANG_W-1:0] atan_q30(input logic [4:0] idx);
        logic [ANG_W-1:0] v;
        unique case (idx)
            5'd0:  v = 34'h03243F6A8;
            5'd1:  v = 34'h01DAC6705;
            5'd2:  v = 34'h00FADBAFC;
            5'd3:  v = 34'h007F56EA6;
            5'd4:  v = 34'h003FEAB76;
            5'd5:  v = 34'h001FFD55B;
            5'd6:  v = 34'h000FFFAAA;
            5'd7:  v = 34'h0007FFF55;
            5'd8:  v = 34'h0003FFFEA;
            5'd9:  v = 34'h0001FFFFD;
            5'd10: v = 34'h0000FFFFF;
            5'd11: v = 34'h00007FFFF;
            5'd12: v = 34'h00003FFFF;
            5'd13: v = 34'h00001FFFF;
            5'd14: v = 34'h00000FFFF;
            5'd15: v = 34'h000007FFF;
            5'd16: v = 34'h000003FFF;
            5'd17: v = 34'h000001FFF;
            5'd18: v = 34'h000000FFF;
            5'd19: v = 34'h0000007FF;
            5'd20: v = 34'h0000003FF;
            5'd21: v = 34'h0000001FF;
            5'd22: v = 34'h0000000FF;
            5'd23: v = 34'h00000007F;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/wts_req_if.sv =====
// request channel: load or query transaction with one point
// depends on wts_pkg
interface wts_req_if;
    logic                        valid;
    logic                        ready;
    logic                        action;
    logic [wts_pkg::COORD_W-1:0] point_x;
    logic [wts_pkg::COORD_W-1:0] point_y;
    logic                        last_point;

    modport source (output valid, action, point_x, point_y, last_point, input ready);
    modport sink   (input valid, action, point_x, point_y, last_point, output ready);
endinterface

// ===== design/wts_rsp_if.sv =====
// response channel: chosen target, heading and status
// depends on wts_pkg
interface wts_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [wts_pkg::COORD_W-1:0] target_x;
    logic [wts_pkg::COORD_W-1:0] target_y;
    logic [wts_pkg::HEAD_W-1:0]  heading;
    logic                        status;

    modport source (output valid, target_x, target_y, heading, status, input ready);
    modport sink   (input valid, target_x, target_y, heading, status, output ready);
endinterface

// ===== design/wts_cfg_if.sv =====
// configuration write channel for the near threshold register
// depends on wts_pkg
interface wts_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [wts_pkg::THR_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== design/waypoint_target_selector.sv =====
// top level of the waypoint target selector: path store, nearest point scan, cordic heading
// depends on wts_pkg, wts_req_if, wts_rsp_if, wts_cfg_if and wts_ram

// A query on a completed path squares the threshold, then reads, squares and compares each
// waypoint, selects the target and runs the cordic on the segment after it before the
// response goes to the output register; the cordic is skipped when the next waypoint
// coincides with the target or the target is the last waypoint. Every waypoint is read from
// the single ram read port and squared in two passes of one shared 32x32 multiplier. One
// shared add/shift datapath then runs the cordic iterations for the heading. A query without
// a completed path answers with status 1. Requests are taken only while the
// sequencer is idle. A finished response waits in the output register while the next
// request is accepted; the sequencer holds until that register is free.
module waypoint_target_selector (
    input  logic     clk,
    input  logic     rst_n,
    wts_req_if.sink  req,
    wts_rsp_if.source rsp,
    wts_cfg_if.sink  cfg
);
    localparam int AW = wts_pkg::ADDR_W;
    localparam int CW = wts_pkg::CNT_W;
    localparam int VW = wts_pkg::VEC_W;
    localparam int ZW = wts_pkg::ANG_W;

    typedef enum logic [13:0] {
        S_IDLE = 14'b00000000000001,
        S_THR  = 14'b00000000000010,
        S_THRS = 14'b00000000000100,
        S_RD   = 14'b00000000001000,
        S_DIF  = 14'b00000000010000,
        S_SQX  = 14'b00000000100000,
        S_SQY  = 14'b00000001000000,
        S_CMP  = 14'b00000010000000,
        S_SEL  = 14'b00000100000000,
        S_RT   = 14'b00001000000000,
        S_RN   = 14'b00010000000000,
        S_COR  = 14'b00100000000000,
        S_FIN  = 14'b01000000000000,
        S_EMIT = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [wts_pkg::THR_W-1:0] thr_reg;
    logic [CW-1:0]             count_reg;
    logic                      path_ready_reg;
    logic                      loading_reg;

    logic [AW-1:0]  idx_reg;
    logic [AW-1:0]  k_reg;
    logic [AW-1:0]  t_reg;
    logic [31:0]    ax_reg, ay_reg;
    logic [63:0]    prod_reg, sx_reg, thr2_reg;
    logic [64:0]    best_reg;
    logic [wts_pkg::COORD_W-1:0] qx_reg, qy_reg, tx_reg, ty_reg;
    logic signed [VW-1:0] cx_reg, cy_reg;
    logic signed [ZW-1:0] z_reg;
    logic [wts_pkg::ITER_W-1:0] it_reg;
    logic [wts_pkg::HEAD_W-1:0] hd_reg;
    logic                      st_reg;

    logic                        out_valid_reg;
    logic [wts_pkg::COORD_W-1:0] out_x_reg, out_y_reg;
    logic [wts_pkg::HEAD_W-1:0]  out_h_reg;
    logic                        out_s_reg;

    // ram
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [63:0]   ram_rdata;
    logic [31:0]   rd_x, rd_y;

    // load path
    logic [CW-1:0] base_cnt;
    logic          req_fire;

    // shared multiplier
    logic [31:0] mul_a, mul_b;

    logic signed [32:0] dfx, dfy, ndx, ndy;
    logic [64:0]        sum;
    logic               near_ok;
    logic [AW-1:0]      t_sel;
    logic signed [VW-1:0] xs, ys;
    logic signed [ZW-1:0] ang, zr;
    logic               emit_ok;

    assign req_fire  = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign emit_ok   = !out_valid_reg || rsp.ready;

    assign base_cnt  = loading_reg ? count_reg : '0;
    assign ram_we    = req_fire && !req.action && (base_cnt < CW'(wts_pkg::MAX_POINTS));
    assign ram_waddr = base_cnt[AW-1:0];

    assign rd_x = ram_rdata[31:0];
    assign rd_y = ram_rdata[63:32];

    wts_ram #(.WIDTH(64), .DEPTH(wts_pkg::MAX_POINTS)) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({req.point_y, req.point_x}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign dfx = $signed({qx_reg[31], qx_reg}) - $signed({rd_x[31], rd_x});
    assign dfy = $signed({qy_reg[31], qy_reg}) - $signed({rd_y[31], rd_y});
    assign ndx = $signed({rd_x[31], rd_x}) - $signed({tx_reg[31], tx_reg});
    assign ndy = $signed({rd_y[31], rd_y}) - $signed({ty_reg[31], ty_reg});

    assign sum     = {1'b0, sx_reg} + {1'b0, prod_reg};
    assign near_ok = (best_reg <= {1'b0, thr2_reg}) && (({1'b0, k_reg} + CW'(1)) < count_reg);
    assign t_sel   = near_ok ? (k_reg + AW'(1)) : k_reg;

    assign xs  = cx_reg >>> it_reg;
    assign ys  = cy_reg >>> it_reg;
    assign ang = $signed(wts_pkg::atan_q30(5'(it_reg)));
    assign zr  = (z_reg + $signed(wts_pkg::ROUND_BIAS)) >>> 17;

    always_comb
    begin
        mul_a = ax_reg;
        mul_b = ax_reg;
        unique case (state_reg)
            S_THR:   begin mul_a = {1'b0, thr_reg}; mul_b = {1'b0, thr_reg}; end
            S_SQY:   begin mul_a = ay_reg; mul_b = ay_reg; end
            default: begin mul_a = ax_reg; mul_b = ax_reg; end
        endcase
    end

    always_comb
    begin
        unique case (state_reg)
            S_SEL:   ram_raddr = t_sel;
            S_RT:    ram_raddr = t_reg + AW'(1);
            default: ram_raddr = idx_reg;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire && req.action)
                begin
                    if (!path_ready_reg || count_reg == '0)
                        state_next = S_EMIT;
                    else
                        state_next = S_THR;
                end
            end
            S_THR:  state_next = S_THRS;
            S_THRS: state_next = S_RD;
            S_RD:   state_next = S_DIF;
            S_DIF:  state_next = S_SQX;
            S_SQX:  state_next = S_SQY;
            S_SQY:  state_next = S_CMP;
            S_CMP:
            begin
                if (({1'b0, idx_reg} + CW'(1)) == count_reg)
                    state_next = S_SEL;
                else
                    state_next = S_RD;
            end
            S_SEL:  state_next = S_RT;
            S_RT:
            begin
                if (({1'b0, t_reg} + CW'(1)) < count_reg)
                    state_next = S_RN;
                else
                    state_next = S_EMIT;
            end
            S_RN:
            begin
                if (ndx == '0 && ndy == '0)
                    state_next = S_EMIT;
                else
                    state_next = S_COR;
            end
            S_COR:
            begin
                if (it_reg == wts_pkg::ITER_W'(wts_pkg::CORDIC_STEPS - 1))
                    state_next = S_FIN;
            end
            S_FIN:  state_next = S_EMIT;
            S_EMIT:
            begin
                if (emit_ok)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            thr_reg        <= wts_pkg::THR_RESET;
            count_reg      <= '0;
            path_ready_reg <= 1'b0;
            loading_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid)
            begin
                thr_reg <= cfg.data;
            end
            if (req_fire && !req.action)
            begin
                if (base_cnt < CW'(wts_pkg::MAX_POINTS))
                    count_reg <= base_cnt + CW'(1);
                else
                    count_reg <= base_cnt;
                if (req.last_point)
                begin
                    loading_reg    <= 1'b0;
                    path_ready_reg <= 1'b1;
                end
                else
                begin
                    loading_reg <= 1'b1;
                    if (!loading_reg)
                        path_ready_reg <= 1'b0;
                end
            end
            if (rsp.valid && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == S_EMIT && emit_ok)
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        unique case (state_reg)
            S_IDLE:
            begin
                qx_reg  <= req.point_x;
                qy_reg  <= req.point_y;
                idx_reg <= '0;
                tx_reg  <= '0;
                ty_reg  <= '0;
                hd_reg  <= '0;
                st_reg  <= 1'b1;
            end
            S_THRS: thr2_reg <= prod_reg;
            S_DIF:
            begin
                ax_reg <= dfx[32] ? 32'(-dfx) : dfx[31:0];
                ay_reg <= dfy[32] ? 32'(-dfy) : dfy[31:0];
            end
            S_SQY: sx_reg <= prod_reg;
            S_CMP:
            begin
                // ties go to the later waypoint
                if (idx_reg == '0 || sum <= best_reg)
                begin
                    best_reg <= sum;
                    k_reg    <= idx_reg;
                end
                idx_reg <= idx_reg + AW'(1);
            end
            S_SEL: t_reg <= t_sel;
            S_RT:
            begin
                tx_reg <= rd_x;
                ty_reg <= rd_y;
                st_reg <= 1'b0;
            end
            S_RN:
            begin
                it_reg <= '0;
                // pre-rotate the left half plane by a quarter turn
                if (ndx < 0 && ndy >= 0)
                begin
                    z_reg  <= $signed(wts_pkg::HALF_PI_Q30);
                    cx_reg <= VW'(ndy);
                    cy_reg <= -VW'(ndx);
                end
                else if (ndx < 0)
                begin
                    z_reg  <= -$signed(wts_pkg::HALF_PI_Q30);
                    cx_reg <= -VW'(ndy);
                    cy_reg <= VW'(ndx);
                end
                else
                begin
                    z_reg  <= '0;
                    cx_reg <= VW'(ndx);
                    cy_reg <= VW'(ndy);
                end
            end
            S_COR:
            begin
                it_reg <= it_reg + wts_pkg::ITER_W'(1);
                if (cy_reg >= 0)
                begin
                    cx_reg <= cx_reg + ys;
                    cy_reg <= cy_reg - xs;
                    z_reg  <= z_reg + ang;
                end
                else
                begin
                    cx_reg <= cx_reg - ys;
                    cy_reg <= cy_reg + xs;
                    z_reg  <= z_reg - ang;
                end
            end
            S_FIN:
            begin
                if (zr > $signed(wts_pkg::HEADING_LIMIT))
                    hd_reg <= wts_pkg::HEAD_W'(wts_pkg::HEADING_LIMIT);
                else if (zr < -$signed(wts_pkg::HEADING_LIMIT))
                    hd_reg <= wts_pkg::HEAD_W'(-$signed(wts_pkg::HEADING_LIMIT));
                else
                    hd_reg <= zr[wts_pkg::HEAD_W-1:0];
            end
            S_EMIT:
            begin
                if (emit_ok)
                begin
                    out_x_reg <= tx_reg;
                    out_y_reg <= ty_reg;
                    out_h_reg <= hd_reg;
                    out_s_reg <= st_reg;
                end
            end
            default: ;
        endcase
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.target_x = out_x_reg;
    assign rsp.target_y = out_y_reg;
    assign rsp.heading  = out_h_reg;
    assign rsp.status   = out_s_reg;
endmodule

// ===== design/wts_ram.sv =====
// generic single write, single read ram with registered read data
// no dependencies
module wts_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== test/tb_waypoint_target_selector.sv =====
// self-checking testbench for waypoint_target_selector: directed table, then random paths
// and queries under idle and stall phases; depends on wts_pkg, the three channel interfaces and the design
module tb_waypoint_target_selector;

    localparam int  RUN_LIMIT = 10000000;
    localparam int  RAND_ITEMS = 1900;
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_QUERY = 1'b1;
    localparam logic ST_OK = 1'b0;
    localparam logic ST_NO_PATH = 1'b1;
    localparam longint HALF_PI_ANG = 64'sd1686629713;
    localparam int  HEAD_MAX = 25736;

    typedef struct {
        wts_pkg::coord_t            tx;
        wts_pkg::coord_t            ty;
        logic [wts_pkg::HEAD_W-1:0] hd;
        logic                       st;
    } target_t;

    typedef struct {
        logic            act;
        wts_pkg::coord_t x;
        wts_pkg::coord_t y;
        logic            last;
        bit              typed;
        target_t         res;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    wts_req_if req ();
    wts_rsp_if rsp ();
    wts_cfg_if cfg ();

    waypoint_target_selector dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    always #1 clk = ~clk;

    // predictor state
    wts_pkg::coord_t           path_x [wts_pkg::MAX_POINTS];
    wts_pkg::coord_t           path_y [wts_pkg::MAX_POINTS];
    int                        path_len = 0;
    bit                        path_done = 0;
    bit                        path_loading = 0;
    logic [wts_pkg::THR_W-1:0] near_thr = wts_pkg::THR_RESET;

    target_t targets_due [$];
    int      errors = 0;
    int      cycles = 0;
    int      queries_sent = 0;
    int      loads_sent = 0;
    int      targets_seen = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;

    longint  atan_ang [16] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
        64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
        64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF
    };

    function automatic logic [wts_pkg::HEAD_W-1:0] bearing(longint dx, longint dy);
        longint x, y, z, xs, ys, t;
        x = dx;
        y = dy;
        z = 0;
        if (dx == 0 && dy == 0)
            return '0;
        if (x < 0)
        begin
            if (y >= 0)
            begin
                z = HALF_PI_ANG; t = x; x = y; y = -t;
            end
            else
            begin
                z = -HALF_PI_ANG; t = x; x = -y; y = t;
            end
        end
        for (int i = 0; i < wts_pkg::CORDIC_STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x += ys; y -= xs; z += atan_ang[i];
            end
            else
            begin
                x -= ys; y += xs; z -= atan_ang[i];
            end
        end
        z = (z + 65536) >>> 17;
        if (z > HEAD_MAX) z = HEAD_MAX;
        if (z < -HEAD_MAX) z = -HEAD_MAX;
        return z[wts_pkg::HEAD_W-1:0];
    endfunction

    // applies one accepted transaction to the path model; returns 1 with the target on a query
    function automatic bit select_target(logic act, wts_pkg::coord_t px, wts_pkg::coord_t py,
                                         logic last, output target_t res);
        logic [65:0] best, d, thr2;
        logic [63:0] ax, ay;
        longint      dl;
        int          k, t;
        res = '{tx: '0, ty: '0, hd: '0, st: ST_OK};
        if (act == ACT_LOAD)
        begin
            if (!path_loading)
            begin
                path_len = 0; path_done = 0; path_loading = 1;
            end
            if (path_len < wts_pkg::MAX_POINTS)
            begin
                path_x[path_len] = px; path_y[path_len] = py; path_len++;
            end
            if (last)
            begin
                path_loading = 0; path_done = (path_len > 0);
            end
            return 0;
        end
        if (!path_done || path_len == 0)
        begin
            res.st = ST_NO_PATH;
            return 1;
        end
        best = '0;
        k = 0;
        for (int i = 0; i < path_len; i++)
        begin
            dl = longint'(signed'(px)) - longint'(signed'(path_x[i]));
            ax = (dl < 0) ? -dl : dl;
            dl = longint'(signed'(py)) - longint'(signed'(path_y[i]));
            ay = (dl < 0) ? -dl : dl;
            d = {2'b0, ax * ax} + {2'b0, ay * ay};
            if (i == 0 || d <= best)
            begin
                best = d; k = i;
            end
        end
        thr2 = {35'b0, near_thr} * {35'b0, near_thr};
        t = (best <= thr2 && k + 1 < path_len) ? k + 1 : k;
        if (t + 1 < path_len)
            res.hd = bearing(longint'(signed'(path_x[t+1])) - longint'(signed'(path_x[t])),
                             longint'(signed'(path_y[t+1])) - longint'(signed'(path_y[t])));
        res.tx = path_x[t];
        res.ty = path_y[t];
        return 1;
    endfunction

    task automatic send_item(logic act, wts_pkg::coord_t x, wts_pkg::coord_t y, logic last,
                             bit typed = 0, target_t typed_res = '{default: '0});
        target_t res;
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.action <= act;
        req.point_x <= x;
        req.point_y <= y;
        req.last_point <= last;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        if (select_target(act, x, y, last, res))
        begin
            if (typed)
                res = typed_res;
            targets_due.insert(targets_due.size(), res);
            queries_sent++;
        end
        else
            loads_sent++;
    endtask

    task automatic wait_idle();
        req.valid <= 1'b0;
        while (targets_due.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_threshold(logic [wts_pkg::THR_W-1:0] v);
        wait_idle();
        cfg.valid <= 1'b1;
        cfg.data <= v;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        cfg.valid <= 1'b0;
        near_thr = v;
        @(posedge clk);
    endtask

    function automatic wts_pkg::coord_t rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
            default: return wts_pkg::coord_t'(int'($urandom_range(0, 2000000)) - 1000000);
        endcase
    endfunction

    // a random path, sometimes longer than the store or ended early, followed by queries, some near its waypoints
    task automatic random_path(inout int budget);
        int              n;
        int              nq;
        wts_pkg::coord_t x, y;
        int              r;
        r = $urandom_range(0, 99);
        if (r < 2) n = wts_pkg::MAX_POINTS + $urandom_range(0, 4);
        else if (r < 5) n = 1;
        else n = $urandom_range(2, 10);
        x = rand_coord();
        y = rand_coord();
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 7) != 0)
            begin
                x = ($urandom_range(0, 3) == 0) ? rand_coord()
                                                : x + $urandom_range(0, 200000) - 100000;
                y = ($urandom_range(0, 3) == 0) ? rand_coord()
                                                : y + $urandom_range(0, 200000) - 100000;
            end
            // a stray query in the middle of loading
            if ($urandom_range(0, 30) == 0)
            begin
                send_item(ACT_QUERY, rand_coord(), rand_coord(), 1'($urandom_range(0, 1)));
                budget--;
            end
            send_item(ACT_LOAD, x, y, (i == n - 1) ? 1'b1 : ($urandom_range(0, 60) == 0));
            budget--;
        end
        nq = (n > 20) ? 2 : $urandom_range(1, 6);
        for (int q = 0; q < nq; q++)
        begin
            if ($urandom_range(0, 9) == 0)
                wait_idle();
            if ($urandom_range(0, 2) == 0 || path_len == 0)
                send_item(ACT_QUERY, rand_coord(), rand_coord(), 1'($urandom_range(0, 1)));
            else
            begin
                r = $urandom_range(0, path_len - 1);
                send_item(ACT_QUERY, path_x[r] + $urandom_range(0, 16000) - 8000,
                          path_y[r] + $urandom_range(0, 16000) - 8000,
                          1'($urandom_range(0, 1)));
            end
            budget--;
        end
    endtask

    function automatic dir_row_t row(logic act, wts_pkg::coord_t x, wts_pkg::coord_t y,
                                     logic last, bit typed = 0,
                                     wts_pkg::coord_t ex = '0, wts_pkg::coord_t ey = '0,
                                     logic [wts_pkg::HEAD_W-1:0] eh = '0,
                                     logic es = ST_OK);
        return '{act: act, x: x, y: y, last: last, typed: typed,
                 res: '{tx: ex, ty: ey, hd: eh, st: es}};
    endfunction

    dir_row_t directed [$];

    initial
    begin
        int budget;
        req.valid = 1'b0;
        req.action = ACT_LOAD;
        req.point_x = '0;
        req.point_y = '0;
        req.last_point = 1'b0;
        rsp.ready = 1'b1;
        cfg.valid = 1'b0;
        cfg.data = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed = '{
            row(ACT_QUERY, 32'h0, 32'h0, 1'b0, 1, 0, 0, 0, ST_NO_PATH),
            row(ACT_QUERY, 32'h7FFFFFFF, 32'h80000000, 1'b1, 1, 0, 0, 0, ST_NO_PATH),
            row(ACT_LOAD, 32'h80000000, 32'h80000000, 1'b0),
            row(ACT_QUERY, 32'h0, 32'h0, 1'b0, 1, 0, 0, 0, ST_NO_PATH),
            row(ACT_LOAD, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1),
            row(ACT_QUERY, 32'h80000000, 32'h80000000, 1'b0, 1, 32'h7FFFFFFF, 32'h7FFFFFFF),
            row(ACT_QUERY, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0, 1, 32'h7FFFFFFF, 32'h7FFFFFFF),
            row(ACT_QUERY, 32'h0, 32'h0, 1'b0),
            // coincident points, ties to the later index
            row(ACT_LOAD, 32'h0, 32'h0, 1'b0),
            row(ACT_LOAD, 32'h0, 32'h0, 1'b0),
            row(ACT_LOAD, 32'h10000, 32'h0, 1'b1),
            row(ACT_QUERY, 32'h0, 32'h0, 1'b0, 1, 32'h10000, 32'h0),
            row(ACT_QUERY, -32'sd5000000, 32'h0, 1'b0),
            row(ACT_QUERY, 32'h8000, 32'h0, 1'b1),
            // single point path
            row(ACT_LOAD, 32'h0, 32'h0, 1'b1),
            row(ACT_QUERY, 32'h12345678, 32'h9ABCDEF0, 1'b0, 1, 32'h0, 32'h0),
            row(ACT_LOAD, 32'd100, 32'd200, 1'b0),
            row(ACT_LOAD, -32'sd300000, 32'd400000, 1'b0),
            row(ACT_LOAD, 32'h0, -32'sd65536, 1'b0),
            row(ACT_LOAD, 32'h0, -32'sd65536, 1'b1),
            row(ACT_QUERY, -32'sd299000, 32'd399000, 1'b0),
            row(ACT_QUERY, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0),
            row(ACT_QUERY, 32'd50000, -32'sd70000, 1'b0)
        };
        foreach (directed[i])
            send_item(directed[i].act, directed[i].x, directed[i].y, directed[i].last,
                      directed[i].typed, directed[i].res);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: write_threshold('0);
                1: write_threshold({wts_pkg::THR_W{1'b1}});
                2: write_threshold(wts_pkg::THR_W'($urandom_range(0, 400000)));
                default: write_threshold(wts_pkg::THR_RESET);
            endcase
            send_idle_pct = (phase == 1 || phase == 3) ? 50 : 0;
            recv_stall_pct = (phase == 2) ? 50 : 0;
            if (phase == 3)
            begin
                send_idle_pct = 18;
                recv_stall_pct = 18;
            end
            budget = RAND_ITEMS / 4;
            while (budget > 0)
                random_path(budget);
        end

        wait_idle();
        repeat (50) @(posedge clk);
        $display("covered %0d loads and %0d queries over four thresholds and idle mixes",
                 loads_sent, queries_sent);
        $display("%0d targets checked, %0d mismatches", targets_seen, errors);
        if (errors == 0)
            $display("tb_waypoint_target_selector: done, clean");
        else
            $display("tb_waypoint_target_selector: done, errors");
        $finish;
    end

    // receiver: check each transaction against the oldest expected target
    always @(posedge clk)
    begin
        target_t exp_t;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            targets_seen++;
            if (targets_due.size() == 0)
            begin
                $error("unexpected target transaction");
                errors++;
            end
            else
            begin
                exp_t = targets_due.pop_front();
                if (rsp.target_x !== exp_t.tx)
                begin
                    $error("target_x expected %h got %h", exp_t.tx, rsp.target_x);
                    errors++;
                end
                if (rsp.target_y !== exp_t.ty)
                begin
                    $error("target_y expected %h got %h", exp_t.ty, rsp.target_y);
                    errors++;
                end
                if (rsp.heading !== exp_t.hd)
                begin
                    $error("heading expected %h got %h", exp_t.hd, rsp.heading);
                    errors++;
                end
                if (rsp.status !== exp_t.st)
                begin
                    $error("status expected %b got %b", exp_t.st, rsp.status);
                    errors++;
                end
            end
        end
        rsp.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > RUN_LIMIT)
        begin
            $display("tb_waypoint_target_selector: done, errors");
            $finish;
        end
    end

endmodule

// ===== files.f =====
design/wts_pkg.sv
design/wts_req_if.sv
design/wts_rsp_if.sv
design/wts_cfg_if.sv
design/wts_ram.sv
design/waypoint_target_selector.sv
test/tb_waypoint_target_selector.sv
